[design/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad scan / debounce / chord unit.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int unsigned NumKeys       = 4;
  localparam int unsigned TimerW        = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned KeyCodeW      = 3;
  localparam int unsigned KindW         = 2;
  localparam int unsigned QueueDepthDef = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScanPeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounce   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChordMaskA = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChordHoldA = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChordMaskB = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChordHoldB = 3'd5;

  // reset values of the configuration registers
  localparam logic [TimerW-1:0]  ScanPeriodRst = 16'd10;
  localparam logic [TimerW-1:0]  DebounceRst   = 16'd3;
  localparam logic [TimerW-1:0]  ChordHoldRst  = 16'd100;
  localparam logic [NumKeys-1:0] ChordMaskRst  = 4'd0;

  // event kinds
  localparam logic [KindW-1:0] KindPress  = 2'd0;
  localparam logic [KindW-1:0] KindRepeat = 2'd1;
  localparam logic [KindW-1:0] KindChord  = 2'd2;

  // chord key codes
  localparam logic [KeyCodeW-1:0] CodeChordA = 3'd4;
  localparam logic [KeyCodeW-1:0] CodeChordB = 3'd5;

  // all events caused by one tick, in the order they are reported:
  // chord first, then the repeat, then presses by ascending index
  typedef struct packed {
    logic               chord_v;
    logic               chord_sel;  // 0 chord A, 1 chord B
    logic               rep_v;
    logic [1:0]         rep_key;
    logic [NumKeys-1:0] press;
  } evt_bundle_t;

  function automatic logic bundle_any(evt_bundle_t b);
    bundle_any = b.chord_v | b.rep_v | (|b.press);
  endfunction

  // a zero period behaves as one
  function automatic logic [TimerW-1:0] load_of(logic [TimerW-1:0] p);
    load_of = (p == '0) ? TimerW'(1) : p;
  endfunction

endpackage

[design/keypad_scan_debounce_combo_unit.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce_combo_unit
// Four-button keypad scanner: debounce, key repeat and two chord detectors.
// ----------------------------------------------------------------------------
//  channel  | ports                                       | beat taken when
//  ---------+---------------------------------------------+-------------------
//  tick in  | push, full, button_levels_i                 | push && !full
//  event out| empty, pop, key_code_o, event_kind_o,       | pop && !empty
//           | final_of_tick_o                             |
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i            | cfg_we_i
//
// One tick is taken per cycle while full is low; the front updates all
// timers and masks in that cycle and queues the tick's events as one
// bundle. The back hands out one event beat per cycle while pop is high.
// A tick's first event goes to the bundle queue, then to the output register.
// full rises only when the bundle queue (QueueDepth entries) is full.
// Reset loads the register defaults and starts the scan timer; no sweep.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_combo_unit #(
  parameter int unsigned QueueDepth = kpd_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // tick input
  input  logic                              push,
  output logic                              full,
  input  logic [kpd_pkg::NumKeys-1:0]       button_levels_i,
  // event output
  output logic                              empty,
  input  logic                              pop,
  output logic [kpd_pkg::KeyCodeW-1:0]      key_code_o,
  output logic [kpd_pkg::KindW-1:0]         event_kind_o,
  output logic                              final_of_tick_o
);

  logic                 tick;
  logic                 evt_push, q_pop, q_empty, q_full;
  kpd_pkg::evt_bundle_t evt, q_data;

  // a tick is refused only while the queue is full; ticks with no
  // events never enter the queue
  assign full = q_full;
  assign tick = push && !q_full;

  kpd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .tick_i          (tick),
    .button_levels_i,
    .evt_push_o      (evt_push),
    .evt_o           (evt)
  );

  kpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (evt_push),
    .data_i  (evt),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  kpd_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i       (q_empty),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .key_code_o,
    .event_kind_o,
    .final_of_tick_o
  );

endmodule

[design/kpd_fifo.sv]
// ----------------------------------------------------------------------------
// kpd_fifo
// Small queue of per-tick event bundles between the front and back parts.
// ----------------------------------------------------------------------------
module kpd_fifo #(
  parameter int unsigned Depth = kpd_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kpd_pkg::evt_bundle_t data_i,
  input  logic                 pop_i,
  output kpd_pkg::evt_bundle_t data_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  kpd_pkg::evt_bundle_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> full_o)
    else $error("full queue drained without a pop");

endmodule

[design/kpd_front.sv]
// ----------------------------------------------------------------------------
// kpd_front
// Per-tick timers, debounce, chord tracking; at most one event bundle a tick.
// ----------------------------------------------------------------------------
module kpd_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                 tick_i,
  input  logic [kpd_pkg::NumKeys-1:0]          button_levels_i,
  output logic                                 evt_push_o,
  output kpd_pkg::evt_bundle_t                 evt_o
);

  localparam int unsigned TW = kpd_pkg::TimerW;
  localparam int unsigned NK = kpd_pkg::NumKeys;

  // configuration
  logic [TW-1:0] scan_per_q, deb_per_q, hold_a_q, hold_b_q;
  logic [NK-1:0] mask_a_q, mask_b_q;

  // state
  logic [NK-1:0] scanned_q, scanned_d, held_q, held_d;
  logic [TW-1:0] sc_cnt_q, sc_cnt_d, de_cnt_q, de_cnt_d, ch_cnt_q, ch_cnt_d;
  logic          sc_run_q, sc_run_d, de_run_q, de_run_d, ch_run_q, ch_run_d;
  logic          ac_v_q, ac_v_d, ac_sel_q, ac_sel_d;
  logic          lk_v_q, lk_v_d;
  logic [1:0]    lk_q, lk_d;

  logic          ch_exp, sc_exp, de_exp, match_a, match_b;
  logic [NK-1:0] newm, chg, rel, below, press, cm;
  kpd_pkg::evt_bundle_t evt;

  assign ch_exp = ch_run_q && (ch_cnt_q <= TW'(1));
  assign sc_exp = sc_run_q && (sc_cnt_q <= TW'(1));
  assign de_exp = de_run_q && (de_cnt_q <= TW'(1));
  assign cm     = ac_sel_q ? mask_b_q : mask_a_q;
  assign newm   = ~button_levels_i;

  // debounced mask against the held one
  assign chg     = held_q ^ scanned_q;
  assign rel     = chg & ~scanned_q;
  assign below   = (rel - NK'(1)) & ~rel;  // bits under the first release
  assign press   = chg & scanned_q & below;
  assign match_a = (mask_a_q != '0) && (mask_a_q == scanned_q);
  assign match_b = (mask_b_q != '0) && (mask_b_q == scanned_q);

  always_comb begin
    scanned_d = scanned_q;
    held_d    = held_q;
    sc_cnt_d  = sc_cnt_q;
    sc_run_d  = sc_run_q;
    de_cnt_d  = de_cnt_q;
    de_run_d  = de_run_q;
    ch_cnt_d  = ch_cnt_q;
    ch_run_d  = ch_run_q;
    ac_v_d    = ac_v_q;
    ac_sel_d  = ac_sel_q;
    lk_v_d    = lk_v_q;
    lk_d      = lk_q;
    evt       = '0;
    if (tick_i) begin
      // count down running timers
      if (ch_run_q && ch_cnt_q != '0) ch_cnt_d = ch_cnt_q - TW'(1);
      if (sc_run_q && sc_cnt_q != '0) sc_cnt_d = sc_cnt_q - TW'(1);
      if (de_run_q && de_cnt_q != '0) de_cnt_d = de_cnt_q - TW'(1);
      if (ch_exp) ch_run_d = 1'b0;
      if (sc_exp) sc_run_d = 1'b0;
      if (de_exp) de_run_d = 1'b0;

      if (ch_exp && ac_v_q && ((cm & held_q) == cm)) begin
        evt.chord_v   = 1'b1;
        evt.chord_sel = ac_sel_q;
      end

      if (sc_exp) begin
        if (newm != scanned_q) begin
          scanned_d = newm;
          de_cnt_d  = kpd_pkg::load_of(deb_per_q);
          de_run_d  = 1'b1;
        end else begin
          if (lk_v_q && !ac_v_q) begin
            evt.rep_v   = 1'b1;
            evt.rep_key = lk_q;
          end
          sc_cnt_d = kpd_pkg::load_of(scan_per_q);
          sc_run_d = 1'b1;
        end
      end

      if (de_exp) begin
        if (chg != '0) begin
          if (ac_v_q) begin
            if (scanned_q != cm) begin
              ac_v_d   = 1'b0;
              ch_run_d = 1'b0;
              ch_cnt_d = '0;
            end
          end else if (match_a || match_b) begin
            ac_v_d   = 1'b1;
            ac_sel_d = !match_a;
            lk_v_d   = 1'b0;
            ch_cnt_d = kpd_pkg::load_of(match_a ? hold_a_q : hold_b_q);
            ch_run_d = 1'b1;
          end else begin
            evt.press = press;
            if (rel != '0) begin
              lk_v_d = 1'b0;
            end else begin
              lk_v_d = 1'b1;
              if (press[3])      lk_d = 2'd3;
              else if (press[2]) lk_d = 2'd2;
              else if (press[1]) lk_d = 2'd1;
              else               lk_d = 2'd0;
            end
          end
        end
        held_d   = scanned_q;
        sc_cnt_d = kpd_pkg::load_of(scan_per_q);
        sc_run_d = 1'b1;
      end
    end
  end

  assign evt_o      = evt;
  assign evt_push_o = tick_i && kpd_pkg::bundle_any(evt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_per_q <= kpd_pkg::ScanPeriodRst;
      deb_per_q  <= kpd_pkg::DebounceRst;
      mask_a_q   <= kpd_pkg::ChordMaskRst;
      hold_a_q   <= kpd_pkg::ChordHoldRst;
      mask_b_q   <= kpd_pkg::ChordMaskRst;
      hold_b_q   <= kpd_pkg::ChordHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kpd_pkg::CfgScanPeriod: scan_per_q <= cfg_wdata_i;
        kpd_pkg::CfgDebounce:   deb_per_q  <= cfg_wdata_i;
        kpd_pkg::CfgChordMaskA: mask_a_q   <= cfg_wdata_i[NK-1:0];
        kpd_pkg::CfgChordHoldA: hold_a_q   <= cfg_wdata_i;
        kpd_pkg::CfgChordMaskB: mask_b_q   <= cfg_wdata_i[NK-1:0];
        kpd_pkg::CfgChordHoldB: hold_b_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanned_q <= '0;
      held_q    <= '0;
      sc_cnt_q  <= kpd_pkg::load_of(kpd_pkg::ScanPeriodRst);
      sc_run_q  <= 1'b1;
      de_cnt_q  <= '0;
      de_run_q  <= 1'b0;
      ch_cnt_q  <= '0;
      ch_run_q  <= 1'b0;
      ac_v_q    <= 1'b0;
      ac_sel_q  <= 1'b0;
      lk_v_q    <= 1'b0;
      lk_q      <= '0;
    end else begin
      scanned_q <= scanned_d;
      held_q    <= held_d;
      sc_cnt_q  <= sc_cnt_d;
      sc_run_q  <= sc_run_d;
      de_cnt_q  <= de_cnt_d;
      de_run_q  <= de_run_d;
      ch_cnt_q  <= ch_cnt_d;
      ch_run_q  <= ch_run_d;
      ac_v_q    <= ac_v_d;
      ac_sel_q  <= ac_sel_d;
      lk_v_q    <= lk_v_d;
      lk_q      <= lk_d;
    end
  end

endmodule

[design/kpd_back.sv]
// ----------------------------------------------------------------------------
// kpd_back
// Unpacks event bundles into single result beats, one per cycle when popped.
// ----------------------------------------------------------------------------
module kpd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  kpd_pkg::evt_bundle_t             q_data_i,
  output logic                             q_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [kpd_pkg::KeyCodeW-1:0]     key_code_o,
  output logic [kpd_pkg::KindW-1:0]        event_kind_o,
  output logic                             final_of_tick_o
);

  kpd_pkg::evt_bundle_t work_q, work_d, cur, rest;
  logic                 out_v_q, out_v_d, advance, work_any;
  logic [kpd_pkg::KeyCodeW-1:0] code_d, code_q;
  logic [kpd_pkg::KindW-1:0]    kind_d, kind_q;
  logic                         fin_d, fin_q;

  assign work_any = kpd_pkg::bundle_any(work_q);
  assign advance  = !out_v_q || pop_i;
  assign cur      = work_any ? work_q : (q_empty_i ? '0 : q_data_i);
  assign q_pop_o  = advance && !work_any && !q_empty_i;

  // pick the next event of the current bundle
  always_comb begin
    rest   = cur;
    code_d = '0;
    kind_d = kpd_pkg::KindPress;
    if (cur.chord_v) begin
      rest.chord_v = 1'b0;
      code_d = cur.chord_sel ? kpd_pkg::CodeChordB : kpd_pkg::CodeChordA;
      kind_d = kpd_pkg::KindChord;
    end else if (cur.rep_v) begin
      rest.rep_v = 1'b0;
      code_d = {1'b0, cur.rep_key};
      kind_d = kpd_pkg::KindRepeat;
    end else if (cur.press[0]) begin
      rest.press[0] = 1'b0;
      code_d = 3'd0;
    end else if (cur.press[1]) begin
      rest.press[1] = 1'b0;
      code_d = 3'd1;
    end else if (cur.press[2]) begin
      rest.press[2] = 1'b0;
      code_d = 3'd2;
    end else begin
      rest.press[3] = 1'b0;
      code_d = 3'd3;
    end
    fin_d = !kpd_pkg::bundle_any(rest);
  end

  always_comb begin
    work_d  = work_q;
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = kpd_pkg::bundle_any(cur);
      work_d  = kpd_pkg::bundle_any(cur) ? rest : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      work_q  <= '0;
    end else begin
      out_v_q <= out_v_d;
      work_q  <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
      kind_q <= kind_d;
      fin_q  <= fin_d;
    end
  end

  assign empty_o         = !out_v_q;
  assign key_code_o      = code_q;
  assign event_kind_o    = kind_q;
  assign final_of_tick_o = fin_q;

  a_chord_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && kind_q == kpd_pkg::KindChord |->
      code_q == kpd_pkg::CodeChordA || code_q == kpd_pkg::CodeChordB)
    else $error("chord beat with a single key code");

  a_key_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && kind_q != kpd_pkg::KindChord |-> !code_q[2])
    else $error("key beat with a chord code");

  a_final_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !fin_q |-> work_any)
    else $error("non-final beat with nothing left of its tick");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pop_i |=> out_v_q && $stable(code_q) && $stable(kind_q))
    else $error("waiting beat changed");

endmodule

[verif/keypad_scan_debounce_combo_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_combo_unit_test
// Self-checking bench for the keypad scanner. Ticks of button levels go in
// through the push/full side. A cycle-free predictor of the scan, debounce
// and chord timers works out the events of every accepted tick. Each popped
// event beat is checked against the oldest prediction. Register settings
// change between phases, with the block drained first.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_combo_unit_test;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DirRows      = 29;

  localparam logic [kpd_pkg::KeyCodeW-1:0] KeyNone   = 3'd4;
  localparam logic [1:0]                   ChordNone = 2'd2;
  localparam logic [kpd_pkg::CfgIdxW-1:0]  CfgSpare  = 3'd7;  // decoded to nothing

  typedef struct packed {
    logic [kpd_pkg::KeyCodeW-1:0] code;
    logic [kpd_pkg::KindW-1:0]    kind;
    logic                         fin;
  } key_event_t;

  // one directed tick; typed rows carry the event count and first event
  typedef struct packed {
    logic [kpd_pkg::NumKeys-1:0]  levels;
    logic                         typed;
    logic [2:0]                   n_events;
    logic [kpd_pkg::KeyCodeW-1:0] key;
    logic [kpd_pkg::KindW-1:0]    kind;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                         clk;
  logic                         rst_n         = 1'b0;
  logic                         cfg_we        = 1'b0;
  logic [kpd_pkg::CfgIdxW-1:0]  cfg_idx       = kpd_pkg::CfgScanPeriod;
  logic [kpd_pkg::CfgDataW-1:0] cfg_wdata     = '0;
  logic                         push          = 1'b0;
  logic                         full;
  logic [kpd_pkg::NumKeys-1:0]  button_levels = 4'hF;
  logic                         empty;
  logic                         pop           = 1'b0;
  logic [kpd_pkg::KeyCodeW-1:0] key_code;
  logic [kpd_pkg::KindW-1:0]    event_kind;
  logic                         final_of_tick;

  keypad_scan_debounce_combo_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push           (push),
    .full           (full),
    .button_levels_i(button_levels),
    .empty          (empty),
    .pop            (pop),
    .key_code_o     (key_code),
    .event_kind_o   (event_kind),
    .final_of_tick_o(final_of_tick)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: register copy, timer state, pending events
  // --------------------------------------------------------------------------
  logic [15:0] period_scan, period_settle, chord_a_hold, chord_b_hold;
  logic [3:0]  chord_a_mask, chord_b_mask;

  logic [3:0]                   kp_sampled, kp_held;
  logic [15:0]                  scan_left, settle_left, chord_left;
  bit                           scan_on, settle_on, chord_on;
  logic [1:0]                   chord_sel;
  logic [kpd_pkg::KeyCodeW-1:0] prev_key;

  key_event_t  expected_events[$];
  int unsigned events_predicted = 0;

  // bookkeeping for the run summary and verdict
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned chord_beats = 0;
  int unsigned repeat_beats = 0;

  // idling control; both off for the tail of the run
  bit in_gaps    = 1'b0;
  bit out_stalls = 1'b0;
  bit allow_idle = 1'b1;

  // random level pattern held over several ticks
  logic [3:0]  cur_levels = 4'hF;
  int unsigned hold_left  = 0;

  // hard stop if the event stream hangs
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d events still pending",
               cycles, expected_events.size());
      $display("keypad_scan_debounce_combo_unit_test: FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] period_or_one(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

  // one-shot timer: counts down while running, fires and stops at zero
  function automatic bit count_down(inout logic [15:0] cnt, inout bit on);
    if (!on) return 1'b0;
    if (cnt != 16'd0) cnt = cnt - 16'd1;
    if (cnt == 16'd0) begin
      on = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [3:0] chord_mask_for(input logic [1:0] sel);
    return (sel == 2'd0) ? chord_a_mask : chord_b_mask;
  endfunction

  function automatic void queue_event(input logic [kpd_pkg::KeyCodeW-1:0] code,
                                      input logic [kpd_pkg::KindW-1:0] kind);
    key_event_t ev;
    ev.code = code;
    ev.kind = kind;
    ev.fin  = 1'b0;
    expected_events.push_back(ev);
  endfunction

  // Works out all events of one tick and updates the predicted state.
  // Order within a tick: chord expiry, scan expiry, debounce expiry.
  function automatic int predict_tick(input logic [3:0] levels);
    int         n;
    bit         chord_fire, scan_fire, settle_fire, stop;
    logic [3:0] newm, changed, cm;
    n = 0;
    chord_fire  = count_down(chord_left, chord_on);
    scan_fire   = count_down(scan_left, scan_on);
    settle_fire = count_down(settle_left, settle_on);

    // chord event only if the whole chord is still held
    if (chord_fire && chord_sel != ChordNone) begin
      cm = chord_mask_for(chord_sel);
      if ((cm & kp_held) == cm) begin
        queue_event((chord_sel == 2'd0) ? kpd_pkg::CodeChordA : kpd_pkg::CodeChordB,
                    kpd_pkg::KindChord);
        n++;
      end
    end

    if (scan_fire) begin
      newm = ~levels;
      if (newm != kp_sampled) begin
        // mask moved: scanning pauses while it settles
        kp_sampled  = newm;
        settle_left = period_or_one(period_settle);
        settle_on   = 1'b1;
      end else begin
        // steady mask: repeat the single key, never during a chord
        if (prev_key != KeyNone && chord_sel == ChordNone) begin
          queue_event(prev_key, kpd_pkg::KindRepeat);
          n++;
        end
        scan_left = period_or_one(period_scan);
        scan_on   = 1'b1;
      end
    end

    if (settle_fire) begin
      newm    = kp_sampled;
      changed = kp_held ^ newm;
      if (changed != 4'd0) begin
        if (chord_sel != ChordNone) begin
          // any move off the chord cancels it, no single keys reported
          if (newm != chord_mask_for(chord_sel)) begin
            chord_sel  = ChordNone;
            chord_on   = 1'b0;
            chord_left = 16'd0;
          end
        end else if (chord_a_mask != 4'd0 && chord_a_mask == newm) begin
          // chord A wins when both masks match
          chord_sel  = 2'd0;
          prev_key   = KeyNone;
          chord_left = period_or_one(chord_a_hold);
          chord_on   = 1'b1;
        end else if (chord_b_mask != 4'd0 && chord_b_mask == newm) begin
          chord_sel  = 2'd1;
          prev_key   = KeyNone;
          chord_left = period_or_one(chord_b_hold);
          chord_on   = 1'b1;
        end else begin
          // presses by index; first release clears the key and ends the walk
          stop = 1'b0;
          for (int k = 0; k < 4; k++) begin
            if (!stop && changed[k]) begin
              if (newm[k]) begin
                prev_key = 3'(k);
                queue_event(3'(k), kpd_pkg::KindPress);
                n++;
              end else begin
                prev_key = KeyNone;
                stop     = 1'b1;
              end
            end
          end
        end
      end
      kp_held   = newm;
      scan_left = period_or_one(period_scan);
      scan_on   = 1'b1;
    end

    if (n > 0) expected_events[expected_events.size() - 1].fin = 1'b1;
    events_predicted += n;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    mismatches++;
  endtask

  // one popped event beat vs the oldest prediction
  task automatic check_beat();
    key_event_t want;
    if (expected_events.size() == 0) begin
      flag_mismatch($sformatf("event key %0d kind %0d with nothing pending",
                              key_code, event_kind));
      return;
    end
    want = expected_events.pop_front();
    beats_checked++;
    if (want.kind == kpd_pkg::KindChord) chord_beats++;
    if (want.kind == kpd_pkg::KindRepeat) repeat_beats++;
    if (key_code !== want.code)
      flag_mismatch($sformatf("key_code %0d, want %0d", key_code, want.code));
    if (event_kind !== want.kind)
      flag_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
    if (final_of_tick !== want.fin)
      flag_mismatch($sformatf("final_of_tick %0b, want %0b", final_of_tick,
                              want.fin));
  endtask

  // event side: pop held high, with random stall bursts when enabled
  initial begin
    @(posedge rst_n);
    forever begin
      if (out_stalls && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) check_beat();
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  // one tick beat; predicted on the edge where it is taken
  task automatic send_tick(input logic [3:0] levels, output int n);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push          <= 1'b1;
    button_levels <= levels;
    @(posedge clk);
    while (full) @(posedge clk);
    n = predict_tick(levels);
    ticks_sent++;
  endtask

  // one register write; we stays high so back-to-back writes need no toggle
  task automatic put_reg(input logic [kpd_pkg::CfgIdxW-1:0] idx,
                         input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      kpd_pkg::CfgScanPeriod: period_scan   = data;
      kpd_pkg::CfgDebounce:   period_settle = data;
      kpd_pkg::CfgChordMaskA: chord_a_mask  = data[3:0];
      kpd_pkg::CfgChordHoldA: chord_a_hold  = data;
      kpd_pkg::CfgChordMaskB: chord_b_mask  = data[3:0];
      kpd_pkg::CfgChordHoldB: chord_b_hold  = data;
      default: ;
    endcase
  endtask

  // drain all events, let the pipe go idle, then write
  task automatic drain_then_program(input logic [15:0] scan, settle,
                                    input logic [3:0] ma, input logic [15:0] ha,
                                    input logic [3:0] mb, input logic [15:0] hb);
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    put_reg(kpd_pkg::CfgScanPeriod, scan);
    put_reg(kpd_pkg::CfgDebounce, settle);
    // mask registers keep only the low nibble; junk above it
    put_reg(kpd_pkg::CfgChordMaskA, {12'($urandom), ma});
    put_reg(kpd_pkg::CfgChordHoldA, ha);
    put_reg(kpd_pkg::CfgChordMaskB, {12'($urandom), mb});
    put_reg(kpd_pkg::CfgChordHoldB, hb);
    put_reg(CfgSpare, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Held patterns (single keys, chords, none, all, random) with one-tick
  // glitches mixed in. Runs on past n_items while the event total is short.
  task automatic run_random(input int unsigned n_items, input int unsigned min_events);
    int unsigned i;
    int          n;
    logic [3:0]  lv;
    i = 0;
    while (i < n_items || (events_predicted < min_events && i < 20 * n_items)) begin
      if (allow_idle && i % 16 == 0) begin
        in_gaps    = $urandom_range(0, 2) != 0;
        out_stalls = $urandom_range(0, 2) != 0;
      end
      if (hold_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: cur_levels = ~(4'b0001 << $urandom_range(0, 3));
          3, 4:    cur_levels = ~chord_a_mask;
          5:       cur_levels = ~chord_b_mask;
          6:       cur_levels = 4'hF;
          7:       cur_levels = 4'h0;
          default: cur_levels = 4'($urandom);
        endcase
        hold_left = $urandom_range(1, 12);
      end
      lv = cur_levels;
      hold_left--;
      if ($urandom_range(0, 7) == 0) lv = 4'($urandom);
      send_tick(lv, n);
      i++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed ticks, run with scan 1, debounce 1, chord A = keys 0+1 hold 2,
  // chord B = keys 2+3 hold 1. Scan timer still carries its reset load of 10.
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [DirRows] = '{
    '{4'hF, 1'b1, 3'd0, 3'd0, kpd_pkg::KindPress},     // nothing right after reset
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // first scan, idle keypad
    '{4'hE, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // key 0 down, settling
    '{4'hE, 1'b1, 3'd1, 3'd0, kpd_pkg::KindPress},     // key 0 press
    '{4'hE, 1'b1, 3'd1, 3'd0, kpd_pkg::KindRepeat},    // key 0 repeat
    '{4'hC, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hC, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // chord A armed
    '{4'hC, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // no repeat under a chord
    '{4'hC, 1'b1, 3'd1, kpd_pkg::CodeChordA, kpd_pkg::KindChord},
    '{4'h0, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'h0, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // leaving the chord cancels it
    '{4'h3, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'h3, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // chord B armed
    '{4'h3, 1'b1, 3'd1, kpd_pkg::CodeChordB, kpd_pkg::KindChord},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'hF, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'h0, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'h0, 1'b1, 3'd4, 3'd0, kpd_pkg::KindPress},     // all four pressed in order
    '{4'h5, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},
    '{4'h5, 1'b0, 3'd0, 3'd0, kpd_pkg::KindPress},     // keys 0 and 2 let go, no events
    '{4'h5, 1'b1, 3'd0, 3'd0, kpd_pkg::KindPress}      // no key left to repeat
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int n;
    // predictor at its reset state
    period_scan   = kpd_pkg::ScanPeriodRst;
    period_settle = kpd_pkg::DebounceRst;
    chord_a_mask  = kpd_pkg::ChordMaskRst;
    chord_b_mask  = kpd_pkg::ChordMaskRst;
    chord_a_hold  = kpd_pkg::ChordHoldRst;
    chord_b_hold  = kpd_pkg::ChordHoldRst;
    kp_sampled    = 4'd0;
    kp_held       = 4'd0;
    scan_left     = period_or_one(kpd_pkg::ScanPeriodRst);
    scan_on       = 1'b1;
    settle_left   = 16'd0;
    settle_on     = 1'b0;
    chord_sel     = ChordNone;
    chord_left    = 16'd0;
    chord_on      = 1'b0;
    prev_key      = KeyNone;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    drain_then_program(16'd1, 16'd1, 4'h3, 16'd2, 4'hC, 16'd1);
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    for (int r = 0; r < DirRows; r++) begin
      send_tick(dir_rows[r].levels, n);
      if (dir_rows[r].typed) begin
        if (n != dir_rows[r].n_events)
          flag_mismatch($sformatf("row %0d gives %0d events, want %0d", r, n,
                                  dir_rows[r].n_events));
        else if (n > 0 &&
                 (expected_events[expected_events.size() - n].code != dir_rows[r].key ||
                  expected_events[expected_events.size() - n].kind != dir_rows[r].kind))
          flag_mismatch($sformatf("row %0d first event differs from table", r));
      end
    end

    // short periods, distinct chords
    drain_then_program(16'd2, 16'd1, 4'h5, 16'd3, 4'hA, 16'd4);
    run_random(25, 0);
    // zero periods load as one; identical chords, A must win
    drain_then_program(16'd0, 16'd0, 4'h6, 16'd0, 4'h6, 16'd0);
    run_random(25, 0);
    // all-keys chord A, chord B disabled
    drain_then_program(16'd3, 16'd2, 4'hF, 16'd5, 4'h0, 16'd1);
    run_random(25, 0);

    // top-end periods and holds, no idling from here on
    allow_idle = 1'b0;
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    drain_then_program(16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 4'hF, 16'hFFFF);
    run_random(8, 0);

    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4 * SettleCycles) @(posedge clk);

    $display("%0d ticks driven, %0d event beats checked (%0d repeats, %0d chords)",
             ticks_sent, beats_checked, repeat_beats, chord_beats);
    $display("register sets: reset values, unit, zero, mid-range and top-end periods");
    if (mismatches == 0) begin
      $display("keypad_scan_debounce_combo_unit_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("keypad_scan_debounce_combo_unit_test: FAIL");
    end
    $finish;
  end

endmodule
